FILE: sv/integer_to_decimal_text_macros.svh
// Assertion macros used by the checker file of this block.
// Each macro samples on the rising edge of clk and is off while rst_n is low.
`ifndef INTEGER_TO_DECIMAL_TEXT_MACROS_SVH
`define INTEGER_TO_DECIMAL_TEXT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ITD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/itd_pkg.sv
package itd_pkg;

  // Field widths and digit layout.
  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 8;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = DIGIT_W * NUM_DIGITS;
  localparam int CNT_W      = $clog2(VALUE_W);
  localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);

  // ASCII codes.
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // Converter states.
  typedef enum logic [1:0] {
    D_IDLE,
    D_SHIFT,
    D_DONE
  } dab_state_t;

  // Emitter states.
  typedef enum logic [1:0] {
    E_IDLE,
    E_SKIP,
    E_EMIT
  } emit_state_t;

  // Finished conversion handed from the converter to the emitter.
  typedef struct packed {
    logic              neg;
    logic [BCD_W-1:0]  digits;
  } itd_bcd_t;

endpackage

FILE: sv/itd_dabble.sv
module itd_dabble
  import itd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      bcd_valid,
  input  logic                      bcd_take,
  output itd_bcd_t                  bcd_data
);

  dab_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [VALUE_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic               neg_r, neg_nxt;
  logic [VALUE_W-1:0] raw;
  logic [BCD_W-1:0]   adj;
  logic               accept;

  assign raw       = in_value;
  assign accept    = in_valid && (state_r == D_IDLE);
  assign in_stall  = (state_r != D_IDLE);
  assign bcd_valid = (state_r == D_DONE);
  assign bcd_data  = '{neg: neg_r, digits: bcd_r};

  // Add three to every digit of five or more before the next shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd_r[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
      end else begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd_r[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      D_IDLE: begin
        if (accept) state_nxt = D_SHIFT;
      end
      D_SHIFT: begin
        if (cnt_r == CNT_W'(VALUE_W - 1)) state_nxt = D_DONE;
      end
      D_DONE: begin
        if (bcd_take) state_nxt = D_IDLE;
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  // Datapath: load the magnitude, then shift one bit per cycle into the digits.
  always_comb begin
    cnt_nxt = cnt_r;
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    neg_nxt = neg_r;
    case (state_r)
      D_IDLE: begin
        if (accept) begin
          neg_nxt = raw[VALUE_W-1];
          bin_nxt = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
          bcd_nxt = '0;
          cnt_nxt = '0;
        end
      end
      D_SHIFT: begin
        bcd_nxt = {adj[BCD_W-2:0], bin_r[VALUE_W-1]};
        bin_nxt = {bin_r[VALUE_W-2:0], 1'b0};
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    neg_r <= neg_nxt;
  end

endmodule

FILE: sv/itd_emit.sv
module itd_emit
  import itd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              bcd_valid,
  output logic              bcd_take,
  input  itd_bcd_t          bcd_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAR_W-1:0] out_character,
  output logic              out_is_last
);

  emit_state_t        state_r, state_nxt;
  logic [BCD_W-1:0]   dig_r, dig_nxt;
  logic [LEFT_W-1:0]  left_r, left_nxt;
  logic               sign_r, sign_nxt;
  logic               ov_r, ov_nxt;
  logic [CHAR_W-1:0]  oc_r, oc_nxt;
  logic               ol_r, ol_nxt;
  logic               slot;
  logic [DIGIT_W-1:0] top;
  logic               top_zero;

  assign slot     = !ov_r || !out_stall;
  assign top      = dig_r[BCD_W-1 -: DIGIT_W];
  assign top_zero = (top == '0) && (left_r > LEFT_W'(1));
  assign bcd_take = (state_r == E_IDLE) && bcd_valid;

  assign out_valid     = ov_r;
  assign out_character = oc_r;
  assign out_is_last   = ol_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      E_IDLE: begin
        if (bcd_valid) state_nxt = E_SKIP;
      end
      E_SKIP: begin
        if (!top_zero) state_nxt = E_EMIT;
      end
      E_EMIT: begin
        if (slot && !sign_r && (left_r == LEFT_W'(1))) state_nxt = E_IDLE;
      end
      default: state_nxt = E_IDLE;
    endcase
  end

  // Datapath and output register: drop leading zeros, then one character per transaction.
  always_comb begin
    dig_nxt  = dig_r;
    left_nxt = left_r;
    sign_nxt = sign_r;
    ov_nxt   = slot ? 1'b0 : ov_r;
    oc_nxt   = oc_r;
    ol_nxt   = ol_r;
    case (state_r)
      E_IDLE: begin
        if (bcd_valid) begin
          dig_nxt  = bcd_data.digits;
          sign_nxt = bcd_data.neg;
          left_nxt = LEFT_W'(NUM_DIGITS);
        end
      end
      E_SKIP: begin
        if (top_zero) begin
          dig_nxt  = {dig_r[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
          left_nxt = left_r - LEFT_W'(1);
        end
      end
      E_EMIT: begin
        if (slot) begin
          ov_nxt = 1'b1;
          if (sign_r) begin
            oc_nxt   = CHAR_MINUS;
            ol_nxt   = 1'b0;
            sign_nxt = 1'b0;
          end else begin
            oc_nxt   = CHAR_ZERO + CHAR_W'(top);
            ol_nxt   = (left_r == LEFT_W'(1));
            dig_nxt  = {dig_r[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            left_nxt = left_r - LEFT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r  <= dig_nxt;
    left_r <= left_nxt;
    sign_r <= sign_nxt;
    oc_r   <= oc_nxt;
    ol_r   <= ol_nxt;
  end

endmodule

FILE: sv/integer_to_decimal_text.sv
// Signed 32-bit integer to decimal ASCII text.
// Input channel: in_valid / in_stall carry one two's complement in_value per transaction.
// Output channel: out_valid / out_stall carry one ASCII out_character per transaction,
// most significant first: '-' for negative values, then the digits without leading
// zeros; out_is_last marks the final character. Zero gives the single character '0'.
// Each value gives 1 to 11 output transactions.
// The converter shifts the magnitude into ten BCD digits one bit per cycle; in_stall
// is high while it works and until the emitter takes the result, so a new value is
// taken only once the previous one has been handed to the emitter.
// The emitter drops one leading zero per cycle (up to nine), then sends one
// character per cycle while out_stall is low; it runs on one value while the
// converter works on the next.
// A stall on the output holds the current character in the output register; the
// emitter, and behind it the converter and the input, wait.
// Reset (rst_n low, synchronous) drops any value in flight and empties the output.
module integer_to_decimal_text
  import itd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [CHAR_W-1:0]         out_character,
  output logic                      out_is_last
);

  logic     bcd_valid;
  logic     bcd_take;
  itd_bcd_t bcd_data;

  // Bit-serial binary to BCD conversion.
  itd_dabble u_dabble (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_value  (in_value),
    .bcd_valid (bcd_valid),
    .bcd_take  (bcd_take),
    .bcd_data  (bcd_data)
  );

  // Digit-serial text output.
  itd_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .bcd_valid     (bcd_valid),
    .bcd_take      (bcd_take),
    .bcd_data      (bcd_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_is_last   (out_is_last)
  );

endmodule

FILE: sv/itd_checker.sv
`include "integer_to_decimal_text_macros.svh"

module itd_checker
  import itd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [CHAR_W-1:0] out_character,
  input logic              out_is_last
);

  // A stalled character stays put.
  `ITD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_character) && $stable(out_is_last), "stalled output changed")

  // Only a minus sign or a decimal digit is ever sent.
  `ITD_ASSERT_NOW(a_char_code, out_valid, (out_character == CHAR_MINUS) || ((out_character >= CHAR_ZERO) && (out_character <= CHAR_ZERO + 8'd9)), "bad character code")

  // The minus sign is always followed by digits.
  `ITD_ASSERT_NOW(a_minus_not_last, out_valid && (out_character == CHAR_MINUS), !out_is_last, "minus marked last")

  // The converter is busy right after it takes a value.
  `ITD_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "input not stalled after transaction")

endmodule

bind integer_to_decimal_text itd_checker u_itd_checker (.*);
